FILE: src/bsw_pkg.sv
// ----------------------------------------------------------------------------
// bsw_pkg: shared types and constants
// Widths, mode and command codes, and the divider handshake structs used by
// the ball sample Welford statistics block.
// ----------------------------------------------------------------------------
package bsw_pkg;

  localparam int unsigned DIMS_W     = 7;
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned SQ_W       = 40;
  localparam int unsigned PSUM_W     = 48;
  localparam int unsigned COUNT_W    = 40;
  localparam int unsigned STAT_W     = 48;
  localparam int unsigned M2_W       = 64;
  localparam int unsigned DIV_NUM_W  = 96;
  localparam int unsigned DIV_STEP_W = 7;

  localparam logic [DIMS_W-1:0]     DIMS_RESET = 7'd3;
  // 1.0 in Q9.40, one bit wider than the Q8.40 partial sum
  localparam logic [PSUM_W:0]       ONE_Q40    = 49'h100_0000_0000;

  localparam logic [DIV_STEP_W-1:0] STEPS_MEAN = 7'd48;
  localparam logic [DIV_STEP_W-1:0] STEPS_VAR  = 7'd72;
  localparam logic [DIV_STEP_W-1:0] STEPS_ERR  = 7'd96;

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_REPORT = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_REPORT = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STAT_W-1:0] x;
  } cmd_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
    logic [DIV_NUM_W-1:0]  num;
    logic [COUNT_W-1:0]    den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

FILE: src/bsw_in_if.sv
// ----------------------------------------------------------------------------
// bsw_in_if: input item channel
// Valid/ready channel carrying one mode and one uniform sample per word.
// ----------------------------------------------------------------------------
interface bsw_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [bsw_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output mode, output sample, input ready);
  modport sink   (input valid, input mode, input sample, output ready);
endinterface

FILE: src/bsw_out_if.sv
// ----------------------------------------------------------------------------
// bsw_out_if: statistics report channel
// Valid/ready channel carrying one statistics report per word.
// ----------------------------------------------------------------------------
interface bsw_out_if;
  logic                         valid;
  logic                         ready;
  logic [bsw_pkg::COUNT_W-1:0]  accepted_count;
  logic [bsw_pkg::STAT_W-1:0]   mean_value;
  logic [bsw_pkg::STAT_W-1:0]   variance;
  logic [bsw_pkg::STAT_W-1:0]   std_dev;
  logic [bsw_pkg::STAT_W-1:0]   std_error;
  logic                         empty_res;

  modport source (output valid, output accepted_count, output mean_value, output variance,
                  output std_dev, output std_error, output empty_res, input ready);
  modport sink   (input valid, input accepted_count, input mean_value, input variance,
                  input std_dev, input std_error, input empty_res, output ready);
endinterface

FILE: src/bsw_cfg_if.sv
// ----------------------------------------------------------------------------
// bsw_cfg_if: configuration write channel
// Valid/ready channel carrying the point_dims register value.
// ----------------------------------------------------------------------------
interface bsw_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bsw_pkg::DIMS_W-1:0]  point_dims;

  modport source (output valid, output point_dims, input ready);
  modport sink   (input valid, input point_dims, output ready);
endinterface

FILE: src/bsw_front.sv
// ----------------------------------------------------------------------------
// bsw_front: sample front end
// Squares samples, builds the partial sum of a point, runs the unit ball
// test and turns items into update, report and clear commands.
// ----------------------------------------------------------------------------
module bsw_front #(
  parameter int unsigned MAX_DIMS = 64
) (
  input  logic           clk,
  input  logic           rst,
  bsw_in_if.sink         sample_in,
  input  logic [bsw_pkg::DIMS_W-1:0] point_dims,
  output logic           push,
  output bsw_pkg::cmd_t  push_cmd,
  input  logic           full
);

  localparam int unsigned DIM_W = $clog2(MAX_DIMS + 1);
  localparam int unsigned CMP_W = (DIM_W > bsw_pkg::DIMS_W) ? DIM_W : bsw_pkg::DIMS_W;

  logic                            s1_valid;
  logic [1:0]                      s1_mode;
  logic [bsw_pkg::SAMPLE_W-1:0]    s1_sample;
  logic                            s2_valid;
  logic [1:0]                      s2_mode;
  logic [bsw_pkg::SQ_W-1:0]        s2_sq;
  logic [bsw_pkg::PSUM_W-1:0]      psum;
  logic [bsw_pkg::PSUM_W-1:0]      psum_next;
  logic [DIM_W-1:0]                coord;
  logic [DIM_W-1:0]                coord_next;

  logic [2*bsw_pkg::SAMPLE_W-1:0]  square;
  logic [bsw_pkg::PSUM_W:0]        sum;
  logic [CMP_W-1:0]                pd_ext;
  logic [CMP_W-1:0]                dims;
  logic                            last;
  logic                            need;
  logic                            go;

  assign square = s1_sample * s1_sample;

  always_comb begin
    pd_ext = CMP_W'(point_dims);
    if (pd_ext == '0) begin
      dims = CMP_W'(1);
    end else if (pd_ext > CMP_W'(MAX_DIMS)) begin
      dims = CMP_W'(MAX_DIMS);
    end else begin
      dims = pd_ext;
    end
    last = ({1'b0, CMP_W'(coord)} + (CMP_W+1)'(1)) >= {1'b0, dims};
    sum  = {1'b0, psum} + (bsw_pkg::PSUM_W+1)'(s2_sq);
  end

  always_comb begin
    need       = 1'b0;
    push_cmd   = '{op: bsw_pkg::OP_REPORT, x: '0};
    psum_next  = psum;
    coord_next = coord;
    case (bsw_pkg::mode_t'(s2_mode))
      bsw_pkg::MODE_SAMPLE: begin
        if (last) begin
          psum_next  = '0;
          coord_next = '0;
          if (sum < bsw_pkg::ONE_Q40) begin
            need     = 1'b1;
            push_cmd = '{op: bsw_pkg::OP_UPDATE, x: {psum[bsw_pkg::SQ_W-1:0], 8'd0}};
          end
        end else begin
          psum_next  = sum[bsw_pkg::PSUM_W] ? '1 : sum[bsw_pkg::PSUM_W-1:0];
          coord_next = coord + DIM_W'(1);
        end
      end
      bsw_pkg::MODE_REPORT: begin
        need = 1'b1;
      end
      bsw_pkg::MODE_CLEAR: begin
        need       = 1'b1;
        push_cmd   = '{op: bsw_pkg::OP_CLEAR, x: '0};
        psum_next  = '0;
        coord_next = '0;
      end
      default: begin
        need = 1'b0;
      end
    endcase
  end

  // hold the whole pipe while a command waits for queue space
  assign go              = !(s2_valid && need && full);
  assign push            = s2_valid && need && !full;
  assign sample_in.ready = go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      psum     <= '0;
      coord    <= '0;
    end else if (go) begin
      s1_valid <= sample_in.valid;
      s2_valid <= s1_valid;
      if (s2_valid) begin
        psum  <= psum_next;
        coord <= coord_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1_mode   <= sample_in.mode;
      s1_sample <= sample_in.sample;
      s2_mode   <= s1_mode;
      s2_sq     <= square[2*bsw_pkg::SAMPLE_W-1:24];
    end
  end

endmodule

FILE: src/bsw_queue.sv
// ----------------------------------------------------------------------------
// bsw_queue: command queue
// Small FIFO between the front end and the statistics engine.
// ----------------------------------------------------------------------------
module bsw_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bsw_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output bsw_pkg::cmd_t  head,
  output logic           full,
  output logic           empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bsw_pkg::cmd_t     entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: src/bsw_div.sv
// ----------------------------------------------------------------------------
// bsw_div: iterative divider
// Restoring division, one quotient bit a cycle, numerator taken from the top.
// ----------------------------------------------------------------------------
module bsw_div (
  input  logic               clk,
  input  logic               rst,
  input  bsw_pkg::div_req_t  req,
  output bsw_pkg::div_rsp_t  rsp
);

  logic                               busy;
  logic                               done;
  logic [bsw_pkg::DIV_STEP_W-1:0]     cnt;
  logic [bsw_pkg::COUNT_W-1:0]        rem;
  logic [bsw_pkg::COUNT_W-1:0]        den;
  logic [bsw_pkg::DIV_NUM_W-1:0]      numr;
  logic [bsw_pkg::DIV_NUM_W-1:0]      quo;
  logic [bsw_pkg::COUNT_W:0]          trial;
  logic [bsw_pkg::COUNT_W:0]          diff;
  logic                               ge;

  always_comb begin
    trial = {rem, numr[bsw_pkg::DIV_NUM_W-1]};
    ge    = trial >= {1'b0, den};
    diff  = trial - {1'b0, den};
  end

  assign rsp = '{done: done, quo: quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // pulse done for one cycle after the last step
      done <= !req.start && busy && (cnt == bsw_pkg::DIV_STEP_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - bsw_pkg::DIV_STEP_W'(1);
        if (cnt == bsw_pkg::DIV_STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      den  <= req.den;
      numr <= req.num;
      quo  <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[bsw_pkg::COUNT_W-1:0] : trial[bsw_pkg::COUNT_W-1:0];
      numr <= {numr[bsw_pkg::DIV_NUM_W-2:0], 1'b0};
      quo  <= {quo[bsw_pkg::DIV_NUM_W-2:0], ge};
    end
  end

endmodule

FILE: src/bsw_back.sv
// ----------------------------------------------------------------------------
// bsw_back: statistics engine
// Runs Welford updates, clears and reports from the command queue, with a
// shared divider, a bit-serial square root and a sliced M2 multiplier.
// ----------------------------------------------------------------------------
module bsw_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  input  bsw_pkg::cmd_t      head,
  output logic               pop,
  output bsw_pkg::div_req_t  div_req,
  input  bsw_pkg::div_rsp_t  div_rsp,
  bsw_out_if.source          stats_out
);

  localparam int unsigned SW = bsw_pkg::STAT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_UDIV, S_UERR, S_UMUL, S_UEND, S_VDIV, S_SQ1, S_EDIV, S_SQ2, S_OUT
  } state_t;

  state_t                          state;
  logic [bsw_pkg::COUNT_W-1:0]     n;
  logic [SW-1:0]                   mean;
  logic [bsw_pkg::M2_W-1:0]        m2;
  logic [SW-1:0]                   x_r;
  logic                            neg;
  logic [SW-1:0]                   mnew;
  logic [SW-1:0]                   eabs;
  logic [2*SW-1:0]                 acc;
  logic [1:0]                      k;
  logic [SW-1:0]                   mag_r;
  logic [SW-1:0]                   var_r;
  logic [SW-1:0]                   sd;
  logic [SW-1:0]                   se;
  logic [2*SW-1:0]                 sq_op;
  logic [SW+3:0]                   sq_rem;
  logic [SW-1:0]                   sq_root;
  logic [5:0]                      sq_cnt;
  logic                            div_start;
  logic [bsw_pkg::DIV_STEP_W-1:0]  div_steps;
  logic [bsw_pkg::DIV_NUM_W-1:0]   div_num;
  logic [bsw_pkg::COUNT_W-1:0]     div_den;
  logic                            ovalid;
  logic [bsw_pkg::COUNT_W-1:0]     o_count;
  logic [SW-1:0]                   o_mean;
  logic [SW-1:0]                   o_var;
  logic [SW-1:0]                   o_sd;
  logic [SW-1:0]                   o_se;

  logic [SW:0]                     dx;
  logic [SW-1:0]                   mag;
  logic [SW:0]                     de;
  logic [SW-1:0]                   qlow;
  logic [SW+15:0]                  prod;
  logic [2*SW-1:0]                 part;
  logic [bsw_pkg::M2_W:0]          m2_sum;
  logic [SW+3:0]                   rem2;
  logic [SW+3:0]                   trial;
  logic                            sq_ge;
  logic                            start_now;

  always_comb begin
    dx   = {1'b0, head.x} - {1'b0, mean};
    mag  = dx[SW] ? SW'(-dx) : dx[SW-1:0];
    de   = {1'b0, x_r} - {1'b0, mnew};
    qlow = div_rsp.quo[SW-1:0];
    prod = mag_r * eabs[{k, 4'd0} +: 16];
    case (k)
      2'd0:    part = (2*SW)'(prod);
      2'd1:    part = {16'd0, prod, 16'd0};
      2'd2:    part = {prod, 32'd0};
      default: part = '0;
    endcase
    m2_sum = {1'b0, m2} + (bsw_pkg::M2_W+1)'(acc[2*SW-1:56]);
    rem2   = {sq_rem[SW+1:0], sq_op[2*SW-1:2*SW-2]};
    trial  = {2'd0, sq_root, 2'b01};
    sq_ge  = rem2 >= trial;
  end

  // kick the divider for a mean step, a variance or a standard error
  assign start_now = ((state == S_IDLE) && !empty &&
                      (((head.op == bsw_pkg::OP_UPDATE) && (n != '1)) ||
                       ((head.op == bsw_pkg::OP_REPORT) && (n > bsw_pkg::COUNT_W'(1))))) ||
                     ((state == S_SQ1) && (sq_cnt == 6'd1));

  assign pop     = (state == S_IDLE) && !empty;
  assign div_req = '{start: div_start, steps: div_steps, num: div_num, den: div_den};

  assign stats_out.valid          = ovalid;
  assign stats_out.accepted_count = o_count;
  assign stats_out.mean_value     = o_mean;
  assign stats_out.variance       = o_var;
  assign stats_out.std_dev        = o_sd;
  assign stats_out.std_error      = o_se;
  assign stats_out.empty_res      = (o_count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      n         <= '0;
      mean      <= '0;
      m2        <= '0;
      x_r       <= '0;
      neg       <= 1'b0;
      mnew      <= '0;
      eabs      <= '0;
      acc       <= '0;
      k         <= '0;
      mag_r     <= '0;
      var_r     <= '0;
      sd        <= '0;
      se        <= '0;
      sq_op     <= '0;
      sq_rem    <= '0;
      sq_root   <= '0;
      sq_cnt    <= '0;
      div_start <= 1'b0;
      div_steps <= '0;
      div_num   <= '0;
      div_den   <= '0;
      ovalid    <= 1'b0;
      o_count   <= '0;
      o_mean    <= '0;
      o_var     <= '0;
      o_sd      <= '0;
      o_se      <= '0;
    end else begin
      div_start <= start_now;
      if (ovalid && stats_out.ready && (state != S_OUT)) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!empty) begin
            case (head.op)
              bsw_pkg::OP_UPDATE: begin
                // drop the point once the count is saturated
                if (n != '1) begin
                  x_r       <= head.x;
                  neg       <= dx[SW];
                  mag_r     <= mag;
                  div_steps <= bsw_pkg::STEPS_MEAN;
                  div_num   <= {mag, SW'(0)};
                  div_den   <= n + bsw_pkg::COUNT_W'(1);
                  state     <= S_UDIV;
                end
              end
              bsw_pkg::OP_REPORT: begin
                var_r <= '0;
                sd    <= '0;
                se    <= '0;
                if (n > bsw_pkg::COUNT_W'(1)) begin
                  div_steps <= bsw_pkg::STEPS_VAR;
                  div_num   <= {m2, 32'd0};
                  div_den   <= n - bsw_pkg::COUNT_W'(1);
                  state     <= S_VDIV;
                end else begin
                  state <= S_OUT;
                end
              end
              bsw_pkg::OP_CLEAR: begin
                n    <= '0;
                mean <= '0;
                m2   <= '0;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_UDIV: begin
          if (div_rsp.done) begin
            mnew  <= neg ? mean - qlow : mean + qlow;
            state <= S_UERR;
          end
        end
        S_UERR: begin
          eabs  <= de[SW] ? SW'(-de) : de[SW-1:0];
          acc   <= '0;
          k     <= '0;
          state <= S_UMUL;
        end
        S_UMUL: begin
          acc <= acc + part;
          k   <= k + 2'd1;
          if (k == 2'd2) begin
            state <= S_UEND;
          end
        end
        S_UEND: begin
          m2    <= m2_sum[bsw_pkg::M2_W] ? '1 : m2_sum[bsw_pkg::M2_W-1:0];
          mean  <= mnew;
          n     <= n + bsw_pkg::COUNT_W'(1);
          state <= S_IDLE;
        end
        S_VDIV: begin
          if (div_rsp.done) begin
            // saturate the variance to Q0.48
            if (|div_rsp.quo[2*SW-1:SW]) begin
              var_r <= '1;
              sq_op <= {{SW{1'b1}}, SW'(0)};
            end else begin
              var_r <= qlow;
              sq_op <= {qlow, SW'(0)};
            end
            sq_rem  <= '0;
            sq_root <= '0;
            sq_cnt  <= 6'(SW);
            state   <= S_SQ1;
          end
        end
        S_SQ1: begin
          sq_rem  <= sq_ge ? rem2 - trial : rem2;
          sq_root <= {sq_root[SW-2:0], sq_ge};
          sq_op   <= {sq_op[2*SW-3:0], 2'd0};
          sq_cnt  <= sq_cnt - 6'd1;
          if (sq_cnt == 6'd1) begin
            sd        <= {sq_root[SW-2:0], sq_ge};
            div_steps <= bsw_pkg::STEPS_ERR;
            div_num   <= {var_r, SW'(0)};
            div_den   <= n;
            state     <= S_EDIV;
          end
        end
        S_EDIV: begin
          if (div_rsp.done) begin
            sq_op   <= div_rsp.quo;
            sq_rem  <= '0;
            sq_root <= '0;
            sq_cnt  <= 6'(SW);
            state   <= S_SQ2;
          end
        end
        S_SQ2: begin
          sq_rem  <= sq_ge ? rem2 - trial : rem2;
          sq_root <= {sq_root[SW-2:0], sq_ge};
          sq_op   <= {sq_op[2*SW-3:0], 2'd0};
          sq_cnt  <= sq_cnt - 6'd1;
          if (sq_cnt == 6'd1) begin
            se    <= {sq_root[SW-2:0], sq_ge};
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ovalid || stats_out.ready) begin
            ovalid  <= 1'b1;
            o_count <= n;
            o_mean  <= mean;
            o_var   <= var_r;
            o_sd    <= sd;
            o_se    <= se;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/ball_sample_welford_stats_top.sv
// ----------------------------------------------------------------------------
// ball_sample_welford_stats_top: unit ball sampling with running statistics
// Front end squares samples and tests points; statistics engine keeps the
// Welford count, mean and M2 and produces reports.
// ----------------------------------------------------------------------------
// Throughput: one sample word per cycle while the command queue has room.
// Flow: a word passes the s1 and s2 front end registers before its command is
//   pushed into the queue; an accepted point then holds the engine for a 48-step
//   divide and 3 M2 slices, a report for 72 + 96 divider steps and two 48-step roots.
// Reset: synchronous; point sum, count, mean and M2 clear to zero, point_dims
//   returns to 3. There is no clearing pass.
module ball_sample_welford_stats_top #(
  parameter int unsigned MAX_DIMS    = 64,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  bsw_in_if.sink      sample_in,
  bsw_out_if.source   stats_out,
  bsw_cfg_if.sink     cfg
);

  // configuration register: samples per point
  logic [bsw_pkg::DIMS_W-1:0] point_dims;

  // command path between front end and engine
  logic               q_push;
  bsw_pkg::cmd_t      q_cmd;
  logic               q_pop;
  bsw_pkg::cmd_t      q_head;
  logic               q_full;
  logic               q_empty;

  // shared divider handshake
  bsw_pkg::div_req_t  div_req;
  bsw_pkg::div_rsp_t  div_rsp;

  // take every configuration word at once
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_dims <= bsw_pkg::DIMS_RESET;
    end else if (cfg.valid) begin
      point_dims <= cfg.point_dims;
    end
  end

  // front end: square, accumulate, test, emit commands
  bsw_front #(
    .MAX_DIMS (MAX_DIMS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sample_in),
    .point_dims (point_dims),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full)
  );

  // decouple front end and engine
  bsw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // one divider serves the mean step, variance and standard error
  bsw_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // statistics engine with output register
  bsw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .head      (q_head),
    .pop       (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .stats_out (stats_out)
  );

  // empty flag must agree with the reported count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    stats_out.valid |-> (stats_out.empty_res == (stats_out.accepted_count == '0)))
    else $error("empty flag disagrees with count");

  // empty report carries zero mean, variance and standard deviation
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (stats_out.valid && stats_out.empty_res) |->
      (stats_out.mean_value == '0 && stats_out.variance == '0 && stats_out.std_dev == '0))
    else $error("empty report with nonzero statistics");

  // standard error never exceeds standard deviation
  a_se_le_sd: assert property (@(posedge clk) disable iff (rst)
    stats_out.valid |-> (stats_out.std_error <= stats_out.std_dev))
    else $error("standard error above standard deviation");

  // input stalls only on queue back-pressure
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !sample_in.ready |-> q_full)
    else $error("input stalled without a full queue");

endmodule

FILE: test/ball_sample_welford_stats_top_tb.sv
// ----------------------------------------------------------------------------
// ball_sample_welford_stats_top_tb: self-checking bench for the ball sampler
// Streams sample, report, clear and unused-mode words through the block under
// bursty input and a stalling report sink. A bit-exact Welford model predicts
// every report, and the reports are checked in order, field by field.
// ----------------------------------------------------------------------------
module ball_sample_welford_stats_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bsw_pkg::mode_t                mode;
    logic [bsw_pkg::SAMPLE_W-1:0]  sample;
  } word_t;

  typedef struct {
    logic [bsw_pkg::COUNT_W-1:0] count;
    logic [bsw_pkg::STAT_W-1:0]  mean;
    logic [bsw_pkg::STAT_W-1:0]  var_q;
    logic [bsw_pkg::STAT_W-1:0]  sdev;
    logic [bsw_pkg::STAT_W-1:0]  serr;
    logic                        empty;
  } report_t;

  logic clk;
  logic rst;

  bsw_in_if  sample_in ();
  bsw_out_if stats_out ();
  bsw_cfg_if cfg ();

  ball_sample_welford_stats_top dut (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_in),
    .stats_out (stats_out),
    .cfg       (cfg)
  );

  // Clock: 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Pending words for the driver and reports still owed by the block.
  word_t   pending_words[$];
  report_t owed_reports[$];
  bit      failed;
  logic    hold_long;    // long receiver hold-off, set by its own process
  int      phase_no;

  // ---------------------------------------------------------------------------
  // Welford model state: mirrors the block's registers.
  // ---------------------------------------------------------------------------
  logic [bsw_pkg::DIMS_W-1:0]  dims_reg;
  logic [bsw_pkg::PSUM_W-1:0]  psum;
  logic [bsw_pkg::DIMS_W-1:0]  coord;
  logic [bsw_pkg::COUNT_W-1:0] n_pts;
  logic [bsw_pkg::STAT_W-1:0]  run_mean;
  logic [bsw_pkg::M2_W-1:0]    run_m2;

  // floor(sqrt(w)), at most 48 bits
  function automatic logic [bsw_pkg::STAT_W-1:0] root48(logic [127:0] w);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 47; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= w) r = c;
    end
    return r[bsw_pkg::STAT_W-1:0];
  endfunction

  // Close a point: test it against the unit ball and fold x into the stats.
  function automatic void close_point(logic [bsw_pkg::SQ_W-1:0] last_sq);
    longint       x, delta, mnew, e;
    logic [63:0]  a, b;
    logic [127:0] p;
    logic [64:0]  sum;
    if ({1'b0, psum} + last_sq >= bsw_pkg::ONE_Q40) return;
    if (n_pts == {bsw_pkg::COUNT_W{1'b1}}) return;   // count saturated: drop the point
    n_pts = n_pts + 1;
    x     = longint'({psum, 8'b0});
    delta = x - longint'({16'b0, run_mean});
    mnew  = longint'({16'b0, run_mean}) + delta / longint'({24'b0, n_pts});
    e     = x - mnew;
    a     = (delta < 0) ? -delta : delta;
    b     = (e < 0) ? -e : e;
    p     = 128'(a) * 128'(b);
    sum   = {1'b0, run_m2} + {1'b0, p[119:56]};
    run_m2   = sum[64] ? {bsw_pkg::M2_W{1'b1}} : sum[63:0];
    run_mean = mnew[bsw_pkg::STAT_W-1:0];
  endfunction

  // Advance the model by one accepted word; queue a report where one is due.
  function automatic void apply_word(bsw_pkg::mode_t mode,
                                     logic [bsw_pkg::SAMPLE_W-1:0] smp);
    logic [63:0]                 sq64;
    logic [bsw_pkg::SQ_W-1:0]    sq;
    int unsigned                 d;
    report_t                     rep;
    logic [127:0]                num, q;
    logic [bsw_pkg::STAT_W-1:0]  var_v;
    sq64 = 64'(smp) * 64'(smp);
    sq   = sq64[63:24];
    d    = dims_reg;
    if (d < 1) d = 1;
    if (d > 64) d = 64;
    case (mode)
      bsw_pkg::MODE_SAMPLE: begin
        if (coord + 1 >= d) begin
          close_point(sq);
          psum  = '0;
          coord = '0;
        end else begin
          psum  = psum + sq;   // at most 63 squares: cannot reach saturation
          coord = coord + 1;
        end
      end
      bsw_pkg::MODE_CLEAR: begin
        n_pts = '0; run_mean = '0; run_m2 = '0; psum = '0; coord = '0;
      end
      bsw_pkg::MODE_REPORT: begin
        rep = '{count: n_pts, mean: '0, var_q: '0, sdev: '0, serr: '0,
                empty: (n_pts == 0)};
        if (n_pts >= 1) rep.mean = run_mean;
        if (n_pts >= 2) begin
          num   = {56'b0, run_m2, 8'b0};
          q     = num / (n_pts - 1);
          var_v = (q > 128'hFFFF_FFFF_FFFF) ? {bsw_pkg::STAT_W{1'b1}}
                                            : q[bsw_pkg::STAT_W-1:0];
          num   = {32'b0, var_v, 48'b0};
          rep.var_q = var_v;
          rep.sdev  = root48(num);
          rep.serr  = root48(num / n_pts);
        end
        owed_reports.push_back(rep);
      end
      default: ;  // unused mode: no effect, no report
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of words with random gaps; predict on acceptance.
  // ---------------------------------------------------------------------------
  int    gap_left;
  int    burst_left;
  word_t w;

  always @(posedge clk) begin
    if (rst) begin
      sample_in.valid <= 1'b0;
      gap_left   = 0;
      burst_left = 4;
    end else begin
      if (sample_in.valid && sample_in.ready)
        apply_word(bsw_pkg::mode_t'(sample_in.mode), sample_in.sample);
      // Hold the word until it is taken; otherwise pick the next one.
      if (!sample_in.valid || sample_in.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          sample_in.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          sample_in.valid  <= 1'b1;
          sample_in.mode   <= w.mode;
          sample_in.sample <= w.sample;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            // Mostly no gap so long runs stay back to back.
            gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
          end
        end else begin
          sample_in.valid <= 1'b0;
        end
      end
    end
  end

  // Track point_dims writes in the model at the handshake edge.
  always @(posedge clk) begin
    if (rst) begin
      dims_reg = bsw_pkg::DIMS_RESET;
      psum = '0; coord = '0; n_pts = '0; run_mean = '0; run_m2 = '0;
    end else if (cfg.valid && cfg.ready) begin
      dims_reg = cfg.point_dims;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready rotates among always, one in two and one in eight; long hold-off on demand.
  // ---------------------------------------------------------------------------
  int unsigned rx_cycle;

  always @(posedge clk) begin
    if (rst) begin
      stats_out.ready <= 1'b0;
      rx_cycle = 0;
    end else begin
      rx_cycle++;
      case ((rx_cycle / 500) % 3)
        0:       stats_out.ready <= !hold_long;
        1:       stats_out.ready <= !hold_long && ($urandom_range(0, 1) == 0);
        default: stats_out.ready <= !hold_long && ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Monitor: compare each report word against the oldest prediction.
  report_t want;

  always @(posedge clk) begin
    if (!rst && stats_out.valid && stats_out.ready) begin
      if (owed_reports.size() == 0) begin
        $display("%0t: unexpected report word, count %0d", $time,
                 stats_out.accepted_count);
        failed = 1'b1;
      end else begin
        want = owed_reports.pop_front();
        if (stats_out.accepted_count !== want.count) begin
          $display("%0t: accepted_count expected %0d actual %0d", $time,
                   want.count, stats_out.accepted_count);
          failed = 1'b1;
        end
        if (stats_out.mean_value !== want.mean) begin
          $display("%0t: mean_value expected %h actual %h", $time,
                   want.mean, stats_out.mean_value);
          failed = 1'b1;
        end
        if (stats_out.variance !== want.var_q) begin
          $display("%0t: variance expected %h actual %h", $time,
                   want.var_q, stats_out.variance);
          failed = 1'b1;
        end
        if (stats_out.std_dev !== want.sdev) begin
          $display("%0t: std_dev expected %h actual %h", $time,
                   want.sdev, stats_out.std_dev);
          failed = 1'b1;
        end
        if (stats_out.std_error !== want.serr) begin
          $display("%0t: std_error expected %h actual %h", $time,
                   want.serr, stats_out.std_error);
          failed = 1'b1;
        end
        if (stats_out.empty_res !== want.empty) begin
          $display("%0t: empty_res expected %b actual %b", $time,
                   want.empty, stats_out.empty_res);
          failed = 1'b1;
        end
      end
    end
  end

  // Long hold-off: in phase 2 the receiver stops while the sender keeps
  // offering words, so the command queue fills and stalls input.
  initial begin
    hold_long = 1'b0;
    wait (phase_no == 2);
    repeat (50) @(posedge clk);
    hold_long <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_long <= 1'b0;
  end

  // Watchdog.
  initial begin
    #50ms;
    $display("[ball_sample_welford_stats_top] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void push(bsw_pkg::mode_t m, logic [bsw_pkg::SAMPLE_W-1:0] s);
    pending_words.push_back('{mode: m, sample: s});
  endfunction

  // Random words: mostly samples, with reports sprinkled in and rare clears
  // and unused-mode noise. Half of the samples are scaled down so that high
  // dimension points still land inside the ball.
  function automatic void push_random(int count);
    int unsigned r;
    logic [bsw_pkg::SAMPLE_W-1:0] s;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      s = $urandom();
      if ($urandom_range(0, 1) == 0) s = s >> $urandom_range(1, 6);
      if (r < 88)      push(bsw_pkg::MODE_SAMPLE, s);
      else if (r < 96) push(bsw_pkg::MODE_REPORT, s);
      else if (r < 98) push(bsw_pkg::MODE_CLEAR, s);
      else             push(bsw_pkg::MODE_NONE, s);
    end
  endfunction

  // Wait until every word is sent and every report is back, then let the
  // engine finish any point still in flight.
  task automatic drain();
    do @(posedge clk);
    while (pending_words.size() != 0 || sample_in.valid || owed_reports.size() != 0);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_dims(logic [bsw_pkg::DIMS_W-1:0] v);
    @(posedge clk);
    cfg.valid      <= 1'b1;
    cfg.point_dims <= v;
    do @(posedge clk);
    while (!(cfg.valid && cfg.ready));
    cfg.valid <= 1'b0;
  endtask

  logic [bsw_pkg::DIMS_W-1:0] dims_plan[8] =
    '{7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd3, 7'd5, 7'd17};

  initial begin
    failed    = 1'b0;
    phase_no  = 0;
    rst       = 1'b1;
    sample_in.valid  = 1'b0;
    sample_in.mode   = bsw_pkg::MODE_SAMPLE;
    sample_in.sample = '0;
    stats_out.ready  = 1'b0;
    cfg.valid        = 1'b0;
    cfg.point_dims   = bsw_pkg::DIMS_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset dimension of three.
    push(bsw_pkg::MODE_REPORT, 32'h0);               // empty statistics
    push(bsw_pkg::MODE_SAMPLE, 32'h0);
    push(bsw_pkg::MODE_SAMPLE, 32'h0);
    push(bsw_pkg::MODE_SAMPLE, 32'hFFFF_FFFF);       // zero partial sum, accepted
    push(bsw_pkg::MODE_REPORT, 32'hFFFF_FFFF);       // single point: no spread
    push(bsw_pkg::MODE_SAMPLE, 32'hFFFF_FFFF);
    push(bsw_pkg::MODE_SAMPLE, 32'hFFFF_FFFF);
    push(bsw_pkg::MODE_SAMPLE, 32'hFFFF_FFFF);       // outside the ball
    push(bsw_pkg::MODE_SAMPLE, 32'h8000_0000);
    push(bsw_pkg::MODE_SAMPLE, 32'h5555_5555);
    push(bsw_pkg::MODE_SAMPLE, 32'hAAAA_AAAA);
    push(bsw_pkg::MODE_NONE,   32'h1234_5678);       // unused mode
    push(bsw_pkg::MODE_REPORT, 32'h0);
    push(bsw_pkg::MODE_SAMPLE, 32'h7FFF_FFFF);       // abandon this point with a clear
    push(bsw_pkg::MODE_CLEAR,  32'h0);
    push(bsw_pkg::MODE_REPORT, 32'h0);
    push(bsw_pkg::MODE_SAMPLE, 32'h0000_0001);
    push(bsw_pkg::MODE_SAMPLE, 32'hB504_F333);       // about sqrt(1/2): this point lands well inside the ball
    push(bsw_pkg::MODE_SAMPLE, 32'h0);
    push(bsw_pkg::MODE_SAMPLE, 32'h4000_0000);
    push(bsw_pkg::MODE_SAMPLE, 32'h2000_0000);
    push(bsw_pkg::MODE_SAMPLE, 32'h1000_0000);
    push(bsw_pkg::MODE_REPORT, 32'h0);
    drain();

    // Random phases across the dimension settings, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      phase_no = ph + 1;
      write_dims(dims_plan[ph]);
      // Any point left open by the previous phase spans the write.
      push_random(125);
      drain();      // sender pauses until every report is back
      push_random(125);
      push(bsw_pkg::MODE_REPORT, '0);
      drain();
    end

    if (!failed)
      $display("[ball_sample_welford_stats_top] OK");
    else
      $display("[ball_sample_welford_stats_top] ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
src/bsw_pkg.sv
src/bsw_in_if.sv
src/bsw_out_if.sv
src/bsw_cfg_if.sv
src/bsw_front.sv
src/bsw_queue.sv
src/bsw_div.sv
src/bsw_back.sv
src/ball_sample_welford_stats_top.sv
test/ball_sample_welford_stats_top_tb.sv
